@@ rtl/asfr_pkg.sv @@
// Shared types and constants for the addressed serial frame receiver.
package asfr_pkg;

  localparam int BUFFER_DEPTH_DEF = 64;
  localparam int BYTE_W           = 8;
  localparam int IDX_W            = 6;

  localparam logic [BYTE_W-1:0] CH_X  = 8'h58;
  localparam logic [BYTE_W-1:0] CH_B  = 8'h42;
  localparam logic [BYTE_W-1:0] CH_U  = 8'h55;
  localparam logic [BYTE_W-1:0] CH_S  = 8'h53;
  localparam logic [BYTE_W-1:0] CH_CR = 8'h0d;
  localparam logic [BYTE_W-1:0] CH_LF = 8'h0a;

  typedef enum logic [3:0] {
    ST_HUNT,
    ST_B,
    ST_U,
    ST_S,
    ST_DEST,
    ST_SRC,
    ST_LEN_HI,
    ST_LEN_LO,
    ST_DATA,
    ST_CR,
    ST_LF,
    ST_READ,
    ST_SHOW
  } state_t;

  typedef struct packed {
    logic cap_dest;
    logic cap_src;
    logic cap_len_hi;
    logic cap_len_lo;
    logic wr_data;
    logic rd_start;
    logic rd_issue;
    logic rd_next;
  } cmd_t;

  typedef struct packed {
    logic is_x;
    logic is_b;
    logic is_u;
    logic is_s;
    logic is_cr;
    logic is_lf;
    logic len_ok;
    logic data_done;
    logic addr_match;
    logic rd_last;
  } status_t;

endpackage

@@ rtl/asfr_cfg_if.sv @@
// Configuration write channel: one register, no index.
interface asfr_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ rtl/asfr_rx_if.sv @@
// Received byte channel.
interface asfr_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

@@ rtl/asfr_out_if.sv @@
// Payload result channel.
interface asfr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] payload_byte;
  logic [5:0] payload_index;
  logic [5:0] payload_length;
  logic [7:0] sender_address;
  logic       last_byte;

  modport source (output valid, output payload_byte, output payload_index,
                  output payload_length, output sender_address, output last_byte,
                  input ready);
  modport sink (input valid, input payload_byte, input payload_index,
                input payload_length, input sender_address, input last_byte,
                output ready);
endinterface

@@ rtl/asfr_datapath.sv @@
// Datapath: address register, header capture, payload store and read-out.
module asfr_datapath #(
  parameter int BUFFER_DEPTH = asfr_pkg::BUFFER_DEPTH_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_valid,
  input  logic [asfr_pkg::BYTE_W-1:0]            cfg_data,
  input  logic [asfr_pkg::BYTE_W-1:0]            rx_byte,
  input  asfr_pkg::cmd_t                         cmd,
  output asfr_pkg::status_t                      status,
  output logic [asfr_pkg::BYTE_W-1:0]            payload_byte,
  output logic [asfr_pkg::IDX_W-1:0]             payload_index,
  output logic [asfr_pkg::IDX_W-1:0]             payload_length,
  output logic [asfr_pkg::BYTE_W-1:0]            sender_address,
  output logic                                   last_byte
);
  import asfr_pkg::*;

  localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;

  logic [BYTE_W-1:0] device_address;
  logic              address_matched;
  logic [BYTE_W-1:0] source_address;
  logic [BYTE_W-1:0] len_hi;
  logic [AW-1:0]     len;
  logic              len_ok;
  logic [AW-1:0]     wp;
  logic [AW-1:0]     rd_idx;
  logic [BYTE_W-1:0] rdata;
  logic [BYTE_W-1:0] mem [BUFFER_DEPTH];

  always_ff @(posedge clk) begin
    if (rst) begin
      device_address <= '0;
    end else if (cfg_valid) begin
      device_address <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_dest) begin
      address_matched <= (rx_byte == device_address);
    end
    if (cmd.cap_src) begin
      source_address <= rx_byte;
    end
    if (cmd.cap_len_hi) begin
      len_hi <= rx_byte;
    end
    if (cmd.cap_len_lo) begin
      len    <= rx_byte[AW-1:0];
      len_ok <= (len_hi == '0) && (rx_byte != '0) && (rx_byte < BYTE_W'(BUFFER_DEPTH));
      wp     <= '0;
    end else if (cmd.wr_data) begin
      wp <= AW'(wp + 1'b1);
    end
    if (cmd.rd_start) begin
      rd_idx <= '0;
    end else if (cmd.rd_next) begin
      rd_idx <= AW'(rd_idx + 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_data) begin
      mem[wp] <= rx_byte;
    end
    if (cmd.rd_issue) begin
      rdata <= mem[rd_idx];
    end
  end

  always_comb begin
    status.is_x       = (rx_byte == CH_X);
    status.is_b       = (rx_byte == CH_B);
    status.is_u       = (rx_byte == CH_U);
    status.is_s       = (rx_byte == CH_S);
    status.is_cr      = (rx_byte == CH_CR);
    status.is_lf      = (rx_byte == CH_LF);
    status.len_ok     = len_ok;
    status.data_done  = (AW'(wp + 1'b1) == len);
    status.addr_match = address_matched;
    status.rd_last    = (AW'(rd_idx + 1'b1) == len);
  end

  assign payload_byte   = rdata;
  assign payload_index  = IDX_W'(rd_idx);
  assign payload_length = IDX_W'(len);
  assign sender_address = source_address;
  assign last_byte      = status.rd_last;

endmodule

@@ rtl/asfr_ctrl.sv @@
// Controller: frame parser and payload read-out sequencer.
module asfr_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              rx_valid,
  output logic              rx_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  asfr_pkg::status_t status,
  output asfr_pkg::cmd_t    cmd
);
  import asfr_pkg::*;

  state_t state;
  state_t state_next;
  logic   fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_HUNT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    rx_ready   = (state != ST_READ) && (state != ST_SHOW);
    out_valid  = (state == ST_SHOW);
    fire       = rx_valid && rx_ready;
    unique case (state)
      ST_HUNT:   if (fire) state_next = status.is_x ? ST_B : ST_HUNT;
      ST_B:      if (fire) state_next = status.is_b ? ST_U : ST_HUNT;
      ST_U:      if (fire) state_next = status.is_u ? ST_S : ST_HUNT;
      ST_S:      if (fire) state_next = status.is_s ? ST_DEST : ST_HUNT;
      ST_DEST: begin
        cmd.cap_dest = fire;
        if (fire) state_next = ST_SRC;
      end
      ST_SRC: begin
        cmd.cap_src = fire;
        if (fire) state_next = ST_LEN_HI;
      end
      ST_LEN_HI: begin
        cmd.cap_len_hi = fire;
        if (fire) state_next = ST_LEN_LO;
      end
      ST_LEN_LO: begin
        cmd.cap_len_lo = fire;
        if (fire) state_next = ST_DATA;
      end
      ST_DATA: begin
        cmd.wr_data = fire && status.len_ok;
        if (fire) begin
          priority if (!status.len_ok) state_next = ST_HUNT;
          else if (status.data_done)   state_next = ST_CR;
          else                         state_next = ST_DATA;
        end
      end
      ST_CR:     if (fire) state_next = status.is_cr ? ST_LF : ST_HUNT;
      ST_LF: begin
        if (fire) begin
          if (status.is_lf && status.addr_match) begin
            cmd.rd_start = 1'b1;
            state_next   = ST_READ;
          end else begin
            state_next = ST_HUNT;
          end
        end
      end
      ST_READ: begin
        cmd.rd_issue = 1'b1;
        state_next   = ST_SHOW;
      end
      ST_SHOW: begin
        if (out_ready) begin
          cmd.rd_next = 1'b1;
          state_next  = status.rd_last ? ST_HUNT : ST_READ;
        end
      end
      default:   state_next = ST_HUNT;
    endcase
  end

`ifndef SYNTHESIS
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(rx_ready && out_valid))
    else $error("input accepted during payload read-out");

  a_emit_start: assert property (@(posedge clk) disable iff (rst)
    (fire && state == ST_LF && status.is_lf && status.addr_match) |=> state == ST_READ)
    else $error("matched frame did not start read-out");

  a_emit_end: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && status.rd_last) |=> (rx_ready && state == ST_HUNT))
    else $error("parser not back to hunting after last beat");

  a_write_ok: assert property (@(posedge clk) disable iff (rst)
    cmd.wr_data |-> status.len_ok)
    else $error("payload write with bad length");
`endif

endmodule

@@ rtl/addressed_serial_frame_receiver.sv @@
// Top level: addressed serial frame receiver.
// Parsing takes one received byte per cycle; a byte is accepted whenever no payload is read out.
// After the LF of a matching frame the input stalls; each payload beat is a store read (ST_READ)
// and then the output register (ST_SHOW), held there through output stalls before the next read.
// The first payload beat is valid once the parser has gone from the LF beat through ST_READ to ST_SHOW.
// Synchronous reset: parser hunts for the start byte, device address is 0; the store is not cleared.
module addressed_serial_frame_receiver #(
  parameter int BUFFER_DEPTH = asfr_pkg::BUFFER_DEPTH_DEF
) (
  input  logic  clk,
  input  logic  rst,
  asfr_cfg_if.sink   cfg,
  asfr_rx_if.sink    rx,
  asfr_out_if.source payload
);
  import asfr_pkg::*;

  cmd_t    cmd;
  status_t status;

  assign cfg.ready = 1'b1;

  asfr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .rx_valid  (rx.valid),
    .rx_ready  (rx.ready),
    .out_valid (payload.valid),
    .out_ready (payload.ready),
    .status    (status),
    .cmd       (cmd)
  );

  asfr_datapath #(
    .BUFFER_DEPTH (BUFFER_DEPTH)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg.valid),
    .cfg_data       (cfg.data),
    .rx_byte        (rx.rx_byte),
    .cmd            (cmd),
    .status         (status),
    .payload_byte   (payload.payload_byte),
    .payload_index  (payload.payload_index),
    .payload_length (payload.payload_length),
    .sender_address (payload.sender_address),
    .last_byte      (payload.last_byte)
  );

endmodule

@@ verif/addressed_serial_frame_receiver_checker.sv @@
// Payload checker: follows the frame parser on every accepted byte and compares each payload beat.
`timescale 1ns / 100ps

module frame_payload_checker (
  input  logic       clk,
  input  logic       rst,
  asfr_cfg_if        cfg,
  asfr_rx_if         rx,
  asfr_out_if        payload,
  output int         fails,
  output int         pending,
  output int         beats
);
  import asfr_pkg::*;

  typedef struct {
    logic [7:0] data;
    logic [5:0] idx;
    logic [5:0] len;
    logic [7:0] sender;
    logic       last;
  } payload_beat_t;

  payload_beat_t expected_payload[$];

  state_t      parse_st;
  logic [7:0]  own_addr;
  logic        dest_hit;
  logic [7:0]  src_addr;
  logic [15:0] frame_len;
  logic [5:0]  wr_pos;
  logic [7:0]  frame_store [BUFFER_DEPTH_DEF];
  int          fail_cnt;
  int          beat_cnt;

  assign fails = fail_cnt;
  assign beats = beat_cnt;

  task automatic parse_byte(input logic [7:0] b);
    payload_beat_t nb;
    int k;
    case (parse_st)
      ST_B: parse_st = (b == CH_B) ? ST_U : ST_HUNT;
      ST_U: parse_st = (b == CH_U) ? ST_S : ST_HUNT;
      ST_S: parse_st = (b == CH_S) ? ST_DEST : ST_HUNT;
      ST_DEST: begin
        dest_hit = (b == own_addr);
        parse_st = ST_SRC;
      end
      ST_SRC: begin
        src_addr = b;
        parse_st = ST_LEN_HI;
      end
      ST_LEN_HI: begin
        frame_len = {8'h00, b};
        parse_st = ST_LEN_LO;
      end
      ST_LEN_LO: begin
        frame_len = {frame_len[7:0], b};
        wr_pos = '0;
        parse_st = ST_DATA;
      end
      ST_DATA: begin
        if ({10'd0, wr_pos} < frame_len && frame_len < BUFFER_DEPTH_DEF) begin
          frame_store[wr_pos] = b;
          wr_pos = wr_pos + 6'd1;
          parse_st = ({10'd0, wr_pos} == frame_len) ? ST_CR : ST_DATA;
        end else begin
          parse_st = ST_HUNT;
        end
      end
      ST_CR: parse_st = (b == CH_CR) ? ST_LF : ST_HUNT;
      ST_LF: begin
        if (b == CH_LF && dest_hit) begin
          for (k = 0; k < int'(frame_len) && k < BUFFER_DEPTH_DEF - 1; k++) begin
            nb.data   = frame_store[k];
            nb.idx    = 6'(k);
            nb.len    = frame_len[5:0];
            nb.sender = src_addr;
            nb.last   = (k + 1 == int'(frame_len));
            expected_payload.push_back(nb);
          end
        end
        parse_st = ST_HUNT;
      end
      default: parse_st = (b == CH_X) ? ST_B : ST_HUNT;
    endcase
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      fail_cnt++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  task automatic check_beat();
    payload_beat_t want;
    beat_cnt++;
    if (expected_payload.size() == 0) begin
      fail_cnt++;
      $display("%0t: payload beat with none expected, expected nothing, got byte %0h index %0d",
               $time, payload.payload_byte, payload.payload_index);
    end else begin
      want = expected_payload.pop_front();
      check_field("payload_byte", want.data, payload.payload_byte);
      check_field("payload_index", {2'b00, want.idx}, {2'b00, payload.payload_index});
      check_field("payload_length", {2'b00, want.len}, {2'b00, payload.payload_length});
      check_field("sender_address", want.sender, payload.sender_address);
      check_field("last_byte", {7'd0, want.last}, {7'd0, payload.last_byte});
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      parse_st = ST_HUNT;
      own_addr = '0;
      dest_hit = 1'b0;
      src_addr = '0;
      frame_len = '0;
      wr_pos = '0;
      expected_payload.delete();
    end else begin
      if (cfg.valid && cfg.ready) own_addr = cfg.data;
      if (rx.valid && rx.ready) parse_byte(rx.rx_byte);
      if (payload.valid && payload.ready) check_beat();
    end
    pending <= expected_payload.size();
  end

endmodule

@@ verif/addressed_serial_frame_receiver_tb.sv @@
// Testbench top: drives frames and address settings into the receiver and reports the verdict.
`timescale 1ns / 100ps

module addressed_serial_frame_receiver_tb;
  import asfr_pkg::*;

  logic clk;
  logic rst;
  bit   calm;
  logic [7:0] cur_addr;
  int   bytes_sent;
  int   frame_count;
  int   setting_count;
  int   mismatch_count;
  int   pending_beats;
  int   checked_beats;

  asfr_cfg_if cfg_ch ();
  asfr_rx_if  rx_ch ();
  asfr_out_if out_ch ();

  addressed_serial_frame_receiver uut (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg_ch),
    .rx      (rx_ch),
    .payload (out_ch)
  );

  frame_payload_checker checker_i (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg_ch),
    .rx      (rx_ch),
    .payload (out_ch),
    .fails   (mismatch_count),
    .pending (pending_beats),
    .beats   (checked_beats)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("== FAIL ==");
    $finish;
  end

  function automatic int gap_cycles(input bit quiet);
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] byte_other_than(input logic [7:0] avoid);
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == avoid);
    return b;
  endfunction

  // sink side: ready in bursts with random stalls
  initial begin
    int hold;
    int stall;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      out_ch.ready <= 1'b1;
      hold = $urandom_range(1, 24);
      repeat (hold) @(posedge clk);
      stall = gap_cycles(1'b0);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int gap;
    rx_ch.valid   <= 1'b1;
    rx_ch.rx_byte <= b;
    do @(posedge clk); while (!rx_ch.ready);
    bytes_sent++;
    gap = gap_cycles(calm);
    if (gap > 0) begin
      rx_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    rx_ch.valid <= 1'b0;
    repeat (4) @(posedge clk);
    while (pending_beats != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_address(input logic [7:0] a);
    wait_idle();
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= a;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    cur_addr = a;
    setting_count++;
  endtask

  task automatic send_header(input logic [7:0] dest, input logic [7:0] src,
                             input logic [15:0] len);
    frame_count++;
    send_byte(CH_X);
    send_byte(CH_B);
    send_byte(CH_U);
    send_byte(CH_S);
    send_byte(dest);
    send_byte(src);
    send_byte(len[15:8]);
    send_byte(len[7:0]);
  endtask

  task automatic send_good_frame(input logic [7:0] dest, input int len);
    int i;
    send_header(dest, 8'($urandom_range(0, 255)), 16'(len));
    for (i = 0; i < len; i++) send_byte(8'($urandom_range(0, 255)));
    send_byte(CH_CR);
    send_byte(CH_LF);
  endtask

  function automatic logic [7:0] pick_dest();
    return ($urandom_range(0, 99) < 70) ? cur_addr : 8'($urandom_range(0, 255));
  endfunction

  task automatic random_sequence();
    int r;
    int len;
    int i;
    logic [15:0] bad_len;
    r = $urandom_range(0, 99);
    calm = ($urandom_range(0, 3) == 0);
    if (r < 65) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(56, 63) : $urandom_range(1, 8);
      send_good_frame(pick_dest(), len);
    end else if (r < 75) begin
      // zero or oversized length: dropped on the following byte
      case ($urandom_range(0, 4))
        0:       bad_len = 16'd0;
        1:       bad_len = 16'd64;
        2:       bad_len = 16'hFFFF;
        3:       bad_len = {8'($urandom_range(1, 255)), 8'($urandom_range(0, 63))};
        default: bad_len = 16'($urandom_range(65, 65535));
      endcase
      send_header(pick_dest(), 8'($urandom_range(0, 255)), bad_len);
      send_byte(8'($urandom_range(0, 255)));
    end else if (r < 85) begin
      len = $urandom_range(1, 4);
      send_header(pick_dest(), 8'($urandom_range(0, 255)), 16'(len));
      for (i = 0; i < len; i++) send_byte(8'($urandom_range(0, 255)));
      if ($urandom_range(0, 1) == 0) begin
        send_byte(byte_other_than(CH_CR));
      end else begin
        send_byte(CH_CR);
        send_byte(byte_other_than(CH_LF));
      end
    end else if (r < 92) begin
      // truncated start pattern
      len = $urandom_range(1, 3);
      send_byte(CH_X);
      if (len > 1) send_byte(CH_B);
      if (len > 2) send_byte(CH_U);
      send_byte(8'($urandom_range(0, 255)));
    end else begin
      len = $urandom_range(1, 6);
      for (i = 0; i < len; i++)
        send_byte(($urandom_range(0, 2) == 0) ? CH_X : 8'($urandom_range(0, 255)));
    end
  endtask

  task automatic run_setting(input logic [7:0] a, input int budget, input bit with_max);
    int start;
    set_address(a);
    start = bytes_sent;
    if (with_max) begin
      calm = 1'b0;
      send_good_frame(cur_addr, 63);
    end
    while (bytes_sent - start < budget) random_sequence();
  endtask

  initial begin
    rst           <= 1'b1;
    rx_ch.valid   <= 1'b0;
    rx_ch.rx_byte <= '0;
    cfg_ch.valid  <= 1'b0;
    cfg_ch.data   <= '0;
    cur_addr      = '0;
    calm          = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // reset address 0: one-byte frame with all-ones payload and sender
    frame_count++;
    send_byte(CH_X);
    send_byte(CH_B);
    send_byte(CH_U);
    send_byte(CH_S);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(8'h01);
    send_byte(8'hFF);
    send_byte(CH_CR);
    send_byte(CH_LF);
    // repeated start byte is not rescanned
    send_byte(CH_X);
    send_byte(CH_X);
    send_byte(CH_B);
    send_byte(CH_U);
    send_byte(CH_S);
    // zero length drops the frame on the next beat
    send_header(8'h00, 8'h00, 16'h0000);
    send_byte(CH_X);

    run_setting(8'hFF, 55, 1'b1);
    run_setting(8'h00, 55, 1'b0);
    run_setting(CH_X, 55, 1'b1);
    run_setting(8'($urandom_range(1, 254)), 55, 1'b0);

    wait_idle();
    $display("Sent %0d bytes in %0d frames across %0d address settings",
             bytes_sent, frame_count, setting_count);
    $display("Checked %0d payload beats, %0d mismatches", checked_beats, mismatch_count);
    if (mismatch_count == 0 && pending_beats == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
